// File: rtl/dpc_pkg.sv
// package of shared types and constants for the damage pair coupling block
package dpc_pkg;

    localparam int POS_W   = 32;
    localparam int DMG_W   = 16;
    localparam int CPL_W   = 17;
    localparam int DIM_DEF = 3;
    localparam int QDEPTH  = 2;

    localparam logic [CPL_W-1:0] CPL_ONE = 17'd65536;
    localparam logic [CPL_W-1:0] CPL_MAX = 17'd131071;

    typedef struct packed {
        logic signed [POS_W-1:0] pix;
        logic signed [POS_W-1:0] piy;
        logic signed [POS_W-1:0] piz;
        logic signed [POS_W-1:0] pjx;
        logic signed [POS_W-1:0] pjy;
        logic signed [POS_W-1:0] pjz;
        logic signed [DMG_W-1:0] ti0;
        logic signed [DMG_W-1:0] ti1;
        logic signed [DMG_W-1:0] ti2;
        logic signed [DMG_W-1:0] ti3;
        logic signed [DMG_W-1:0] ti4;
        logic signed [DMG_W-1:0] ti5;
        logic signed [DMG_W-1:0] tj0;
        logic signed [DMG_W-1:0] tj1;
        logic signed [DMG_W-1:0] tj2;
        logic signed [DMG_W-1:0] tj3;
        logic signed [DMG_W-1:0] tj4;
        logic signed [DMG_W-1:0] tj5;
    } pair_t;

    // floor square root step count for a 64 bit radicand
    localparam int SQRT_STEPS = 32;

endpackage

// File: rtl/dpc_front.sv
// front end: holds the first node and forms pair jobs
module dpc_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall_q,
    input  logic signed [dpc_pkg::POS_W-1:0] pos_x,
    input  logic signed [dpc_pkg::POS_W-1:0] pos_y,
    input  logic signed [dpc_pkg::POS_W-1:0] pos_z,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_xx,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_yy,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_zz,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_xy,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_xz,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_yz,
    input  logic                         second_node,
    output logic                         push,
    output dpc_pkg::pair_t               push_data
);
    import dpc_pkg::*;

    logic                    have_reg;
    logic signed [POS_W-1:0] hp_reg [3];
    logic signed [DMG_W-1:0] ht_reg [6];
    logic                    acc;

    assign acc  = in_valid && !in_stall_q;
    assign push = acc && second_node && have_reg;

    always_comb
    begin
        push_data     = '0;
        push_data.pix = hp_reg[0];
        push_data.piy = hp_reg[1];
        push_data.piz = hp_reg[2];
        push_data.pjx = pos_x;
        push_data.pjy = pos_y;
        push_data.pjz = pos_z;
        push_data.ti0 = ht_reg[0];
        push_data.ti1 = ht_reg[1];
        push_data.ti2 = ht_reg[2];
        push_data.ti3 = ht_reg[3];
        push_data.ti4 = ht_reg[4];
        push_data.ti5 = ht_reg[5];
        push_data.tj0 = dmg_xx;
        push_data.tj1 = dmg_yy;
        push_data.tj2 = dmg_zz;
        push_data.tj3 = dmg_xy;
        push_data.tj4 = dmg_xz;
        push_data.tj5 = dmg_yz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            for (int k = 0; k < 3; k++) hp_reg[k] <= '0;
            for (int k = 0; k < 6; k++) ht_reg[k] <= '0;
        end
        else if (acc)
        begin
            if (!second_node)
            begin
                have_reg  <= 1'b1;
                hp_reg[0] <= pos_x;
                hp_reg[1] <= pos_y;
                hp_reg[2] <= pos_z;
                ht_reg[0] <= dmg_xx;
                ht_reg[1] <= dmg_yy;
                ht_reg[2] <= dmg_zz;
                ht_reg[3] <= dmg_xy;
                ht_reg[4] <= dmg_xz;
                ht_reg[5] <= dmg_yz;
            end
            else
            begin
                have_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/dpc_queue.sv
// short job queue between front and back
module dpc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dpc_pkg::pair_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output dpc_pkg::pair_t head
);
    import dpc_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    pair_t         mem_reg [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// File: rtl/dpc_back.sv
// back end: sequencer with shared square root and divider units
module dpc_back
#(
    parameter int DIM = dpc_pkg::DIM_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    input  dpc_pkg::pair_t               job,
    output logic                         job_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dpc_pkg::CPL_W-1:0]    coupling,
    output logic                         saturated,
    output logic                         coincident
);
    import dpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_NORM, S_SQ, S_SQRT, S_DIV, S_ROW, S_RSQ,
        S_NSQRT, S_FORM, S_FIN, S_OUT
    } state_t;

    state_t state_reg;

    logic [32:0]        mag_reg [3];
    logic [2:0]         neg_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        rad_reg;
    logic [63:0]        root_reg;
    logic [63:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        n_reg;
    logic signed [31:0] u_reg [3];
    logic [1:0]         k_reg;
    logic [1:0]         c_reg;
    logic               side_reg;
    logic signed [63:0] racc_reg;
    logic [19:0]        s_reg [2];
    logic [62:0]        dnum_reg;
    logic [31:0]        q_reg;
    logic [CPL_W-1:0]   cpl_reg;
    logic               sat_reg;
    logic               coin_reg;
    logic signed [15:0] tsel;
    logic signed [31:0] usel;
    logic [32:0]        maxm;
    logic [63:0]        rtry;
    logic [63:0]        dtry;
    logic [63:0]        racc_abs;
    logic [31:0]        rrnd;
    logic signed [47:0] prod;

    localparam logic [1:0] DLAST = 2'(DIM - 1);

    function automatic logic signed [15:0] tpick(input pair_t p, input logic s,
                                                 input logic [1:0] r, input logic [1:0] c);
        logic [2:0] slot;
        logic signed [15:0] v;
        slot = 3'd0;
        v = '0;
        if (r == c) slot = {1'b0, r};
        else if ((r == 2'd0 && c == 2'd1) || (r == 2'd1 && c == 2'd0)) slot = 3'd3;
        else if ((r == 2'd0 && c == 2'd2) || (r == 2'd2 && c == 2'd0)) slot = 3'd4;
        else slot = 3'd5;
        case (slot)
            3'd0: v = s ? p.tj0 : p.ti0;
            3'd1: v = s ? p.tj1 : p.ti1;
            3'd2: v = s ? p.tj2 : p.ti2;
            3'd3: v = s ? p.tj3 : p.ti3;
            3'd4: v = s ? p.tj4 : p.ti4;
            default: v = s ? p.tj5 : p.ti5;
        endcase
        return v;
    endfunction

    assign tsel     = tpick(job, side_reg, k_reg, c_reg);
    assign usel     = u_reg[c_reg];
    assign prod     = 48'(tsel) * 48'(usel);
    assign maxm     = (mag_reg[0] > mag_reg[1]) ?
                      ((mag_reg[0] > mag_reg[2]) ? mag_reg[0] : mag_reg[2]) :
                      ((mag_reg[1] > mag_reg[2]) ? mag_reg[1] : mag_reg[2]);
    assign rtry     = root_reg | (64'd1 << {cnt_reg[4:0], 1'b0});
    assign dtry     = {rem_reg[62:0], dnum_reg[62]};
    assign racc_abs = racc_reg[63] ? 64'(-racc_reg) : 64'(racc_reg);
    assign rrnd     = 32'((racc_abs + 64'd524288) >> 20);

    assign job_pop    = (state_reg == S_FIN) ||
                        (state_reg == S_DIFF && maxm == '0);
    assign out_valid  = (state_reg == S_OUT);
    assign coupling   = cpl_reg;
    assign saturated  = sat_reg;
    assign coincident = coin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        logic signed [32:0] d0, d1, d2;
                        d0 = 33'(job.pix) - 33'(job.pjx);
                        d1 = 33'(job.piy) - 33'(job.pjy);
                        d2 = 33'(job.piz) - 33'(job.pjz);
                        mag_reg[0] <= d0[32] ? 33'(-d0) : 33'(d0);
                        mag_reg[1] <= (DIM > 1) ? (d1[32] ? 33'(-d1) : 33'(d1)) : '0;
                        mag_reg[2] <= (DIM > 2) ? (d2[32] ? 33'(-d2) : 33'(d2)) : '0;
                        neg_reg    <= {d2[32], d1[32], d0[32]};
                        state_reg  <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    if (maxm == '0)
                    begin
                        cpl_reg   <= CPL_ONE;
                        sat_reg   <= 1'b0;
                        coin_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (maxm < 33'd536870912)
                    begin
                        for (int k = 0; k < 3; k++) mag_reg[k] <= mag_reg[k] << 1;
                    end
                    else if (maxm >= 33'd1073741824)
                    begin
                        for (int k = 0; k < 3; k++) mag_reg[k] <= mag_reg[k] >> 1;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    acc_reg <= acc_reg + 64'(mag_reg[k_reg][29:0]) * 64'(mag_reg[k_reg][29:0]);
                    if (k_reg == 2'd2)
                    begin
                        rad_reg   <= acc_reg + 64'(mag_reg[2][29:0]) * 64'(mag_reg[2][29:0]);
                        root_reg  <= '0;
                        cnt_reg   <= 6'd31;
                        state_reg <= S_SQRT;
                    end
                    k_reg <= k_reg + 2'd1;
                end
                S_SQRT, S_NSQRT:
                begin
                    if (rad_reg >= rtry)
                    begin
                        rad_reg  <= rad_reg - rtry;
                        root_reg <= (root_reg >> 1) | (64'd1 << {cnt_reg[4:0], 1'b0});
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        if (state_reg == S_SQRT)
                        begin
                            n_reg     <= (rad_reg >= rtry) ? 32'((root_reg >> 1) | 64'd1)
                                                           : 32'(root_reg >> 1);
                            k_reg     <= '0;
                            state_reg <= S_DIV;
                            cnt_reg   <= 6'd63;
                        end
                        else
                        begin
                            cnt_reg         <= cnt_reg - 6'd1;
                            s_reg[side_reg] <= 20'((((rad_reg >= rtry) ?
                                               ((root_reg >> 1) | 64'd1) :
                                               (root_reg >> 1)) + 64'd128) >> 8);
                            if (side_reg)
                                state_reg <= S_FORM;
                            else
                            begin
                                side_reg  <= 1'b1;
                                k_reg     <= '0;
                                c_reg     <= '0;
                                racc_reg  <= '0;
                                acc_reg   <= '0;
                                state_reg <= S_ROW;
                            end
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'd63)
                    begin
                        dnum_reg <= 63'({mag_reg[k_reg][29:0], 30'd0}) + 63'(n_reg >> 1);
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        cnt_reg  <= 6'd62;
                    end
                    else
                    begin
                        if (dtry >= 64'(n_reg))
                        begin
                            rem_reg <= dtry - 64'(n_reg);
                            q_reg   <= {q_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= dtry;
                            q_reg   <= {q_reg[30:0], 1'b0};
                        end
                        dnum_reg <= dnum_reg << 1;
                        if (cnt_reg == 6'd0)
                        begin
                            logic [31:0] qf;
                            qf = (dtry >= 64'(n_reg)) ? {q_reg[30:0], 1'b1}
                                                      : {q_reg[30:0], 1'b0};
                            u_reg[k_reg] <= (k_reg > DLAST) ? 32'sd0 :
                                            (neg_reg[k_reg] ? -$signed(qf) : $signed(qf));
                            cnt_reg <= 6'd63;
                            if (k_reg == 2'd2)
                            begin
                                side_reg  <= 1'b0;
                                k_reg     <= '0;
                                c_reg     <= '0;
                                racc_reg  <= '0;
                                acc_reg   <= '0;
                                state_reg <= S_ROW;
                            end
                            else
                                k_reg <= k_reg + 2'd1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 6'd1;
                        end
                    end
                end
                S_ROW:
                begin
                    racc_reg <= racc_reg + 64'(prod);
                    if (c_reg == DLAST)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_RSQ;
                    end
                    else
                        c_reg <= c_reg + 2'd1;
                end
                S_RSQ:
                begin
                    acc_reg  <= acc_reg + 64'(rrnd) * 64'(rrnd);
                    racc_reg <= '0;
                    if (k_reg == DLAST)
                    begin
                        rad_reg   <= acc_reg + 64'(rrnd) * 64'(rrnd);
                        root_reg  <= '0;
                        cnt_reg   <= 6'd31;
                        state_reg <= S_NSQRT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_ROW;
                    end
                end
                S_FORM:
                begin
                    logic [19:0] mn, mx;
                    logic signed [23:0] fa, fb;
                    logic signed [47:0] f;
                    logic [47:0] cr;
                    mn = (s_reg[0] < s_reg[1]) ? s_reg[0] : s_reg[1];
                    mx = (s_reg[0] < s_reg[1]) ? s_reg[1] : s_reg[0];
                    fa = 24'sd65536 - 24'($signed({1'b0, mx}));
                    fb = 24'sd65536 - 24'($signed({1'b0, mn}));
                    f  = 48'(fa) * 48'(fb) + 48'($signed({1'b0, mn, 16'd0}));
                    cr = 48'((f + 48'sd32768) >>> 16);
                    coin_reg <= 1'b0;
                    if (f <= 0)
                    begin
                        cpl_reg <= '0;
                        sat_reg <= 1'b0;
                    end
                    else if (cr > 48'(CPL_MAX))
                    begin
                        cpl_reg <= CPL_MAX;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        cpl_reg <= cr[16:0];
                        sat_reg <= 1'b0;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/damage_pair_coupling_core.sv
// top level of the damage pair coupling block
// processing: each pair passes through 0 to 29 normalization shifts, three 32-step square
// roots and three divisions in the back end; coincident pairs skip all of these steps
// throughput: one pair at a time in the back end, the next starts in the cycle after the
// result transfer; the front takes an item each cycle while the two-entry queue has room
// reset: asynchronous active low, clears held node, queue and sequencer
module damage_pair_coupling_core
#(
    parameter int DIM = dpc_pkg::DIM_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [dpc_pkg::POS_W-1:0] pos_x,
    input  logic signed [dpc_pkg::POS_W-1:0] pos_y,
    input  logic signed [dpc_pkg::POS_W-1:0] pos_z,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_xx,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_yy,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_zz,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_xy,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_xz,
    input  logic signed [dpc_pkg::DMG_W-1:0] dmg_yz,
    input  logic                             second_node,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [dpc_pkg::CPL_W-1:0]        coupling,
    output logic                             saturated,
    output logic                             coincident
);
    import dpc_pkg::*;

    logic  push, pop, full, nempty;
    pair_t pdata, head;

    assign in_stall = full;

    dpc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall_q(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .dmg_xx(dmg_xx), .dmg_yy(dmg_yy), .dmg_zz(dmg_zz),
        .dmg_xy(dmg_xy), .dmg_xz(dmg_xz), .dmg_yz(dmg_yz),
        .second_node(second_node), .push(push), .push_data(pdata)
    );

    dpc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(pdata), .pop(pop),
        .full(full), .not_empty(nempty), .head(head)
    );

    dpc_back #(.DIM(DIM)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(nempty), .job(head), .job_pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .coupling(coupling),
        .saturated(saturated), .coincident(coincident)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nempty)
        else $error("pop from empty queue");
    a_coin_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coincident) |-> (coupling == CPL_ONE && !saturated))
        else $error("coincident result not one");

endmodule

// File: test/tb_damage_pair_coupling_core.sv
// testbench for the damage pair coupling block: directed and random node pairs checked against a predictor
`timescale 1ns / 1ps

module tb_damage_pair_coupling_core;
    import dpc_pkg::*;

    localparam int LIMIT = 20000;

    typedef struct packed {
        logic [CPL_W-1:0] cpl;
        logic             sat;
        logic             coin;
    } coupling_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [DMG_W-1:0] dmg_xx = '0, dmg_yy = '0, dmg_zz = '0;
    logic signed [DMG_W-1:0] dmg_xy = '0, dmg_xz = '0, dmg_yz = '0;
    logic second_node = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CPL_W-1:0] coupling;
    logic saturated;
    logic coincident;

    coupling_t expected_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    logic signed [POS_W-1:0] node_pos[3];
    logic signed [DMG_W-1:0] node_dmg[6];
    logic                    node_held;

    damage_pair_coupling_core u_top (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] tensor_apply(input logic signed [DMG_W-1:0] t[6],
                                                input longint u[3]);
        int slot[3][3] = '{'{0, 3, 4}, '{3, 1, 5}, '{4, 5, 2}};
        logic [63:0] sq, a;
        longint acc;
        sq = 0;
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            for (int c = 0; c < 3; c++)
                acc += longint'(t[slot[r][c]]) * u[c];
            a = acc < 0 ? -acc : acc;
            a = (a + (64'd1 << 19)) >> 20;
            sq += a * a;
        end
        return (int_sqrt(sq) + 128) >> 8;
    endfunction

    task automatic predict_node(input logic signed [POS_W-1:0] p[3],
                                input logic signed [DMG_W-1:0] t[6], input logic second);
        logic [63:0] mag[3], maxa, s, n, q;
        logic neg[3];
        longint d, u[3], si, sj, mn, mx, f;
        coupling_t e;
        if (!second)
        begin
            node_pos = p;
            node_dmg = t;
            node_held = 1'b1;
            return;
        end
        if (!node_held) return;
        node_held = 1'b0;
        maxa = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'(node_pos[k]) - longint'(p[k]);
            neg[k] = d < 0;
            mag[k] = d < 0 ? -d : d;
            if (mag[k] > maxa) maxa = mag[k];
        end
        if (maxa == 0)
        begin
            e = '{CPL_ONE, 1'b0, 1'b1};
            expected_q.push_back(e);
            return;
        end
        while (maxa < (64'd1 << 29))
        begin
            maxa <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        while (maxa >= (64'd1 << 30))
        begin
            maxa >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        s = 0;
        for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
        n = int_sqrt(s);
        for (int k = 0; k < 3; k++)
        begin
            q = ((mag[k] << 30) + n / 2) / n;
            u[k] = neg[k] ? -longint'(q) : longint'(q);
        end
        si = tensor_apply(node_dmg, u);
        sj = tensor_apply(t, u);
        mn = si < sj ? si : sj;
        mx = si < sj ? sj : si;
        f = (65536 - mx) * (65536 - mn) + mn * 65536;
        e = '{'0, 1'b0, 1'b0};
        if (f > 0)
        begin
            q = (f + (64'd1 << 15)) >> 16;
            if (q > CPL_MAX)
            begin
                q = CPL_MAX;
                e.sat = 1'b1;
            end
            e.cpl = q[CPL_W-1:0];
        end
        expected_q.push_back(e);
    endtask

    task automatic send_node(input logic signed [POS_W-1:0] p[3],
                             input logic signed [DMG_W-1:0] t[6], input logic second);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
        dmg_xx <= t[0]; dmg_yy <= t[1]; dmg_zz <= t[2];
        dmg_xy <= t[3]; dmg_xz <= t[4]; dmg_yz <= t[5];
        second_node <= second;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_node(p, t, second);
        @(negedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(65536 * 8)) - 65536 * 4;
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(65536 * 200)) - 65536 * 100;
        endcase
    endfunction

    function automatic logic signed [DMG_W-1:0] rand_dmg();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(16384));
        endcase
    endfunction

    task automatic send_random_pair(input int shared);
        logic signed [POS_W-1:0] p[3], q[3];
        logic signed [DMG_W-1:0] t[6];
        int kind;
        for (int k = 0; k < 3; k++) p[k] = rand_pos();
        for (int k = 0; k < 6; k++) t[k] = rand_dmg();
        kind = $urandom_range(19);
        if (kind == 0) send_node(p, t, 1'b1);
        if (kind == 1) send_node(p, t, 1'b0);
        send_node(p, t, 1'b0);
        for (int k = 0; k < 3; k++)
            q[k] = (shared != 0 && $urandom_range(2) == 0) ? p[k] : rand_pos();
        if (kind == 2) q = p;
        for (int k = 0; k < 6; k++) t[k] = rand_dmg();
        send_node(q, t, 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed();
        logic signed [POS_W-1:0] p0[3] = '{0, 0, 0};
        logic signed [POS_W-1:0] pmax[3] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        logic signed [POS_W-1:0] pmin[3] = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        logic signed [POS_W-1:0] px[3] = '{65536, 0, 0};
        logic signed [POS_W-1:0] pyz[3] = '{0, -1, 1};
        logic signed [DMG_W-1:0] t0[6] = '{0, 0, 0, 0, 0, 0};
        logic signed [DMG_W-1:0] tone[6] = '{16384, 16384, 16384, 0, 0, 0};
        logic signed [DMG_W-1:0] tmax[6] = '{16'sh7fff, 16'sh7fff, 16'sh7fff,
                                             16'sh7fff, 16'sh7fff, 16'sh7fff};
        logic signed [DMG_W-1:0] tmin[6] = '{16'sh8000, 16'sh8000, 16'sh8000,
                                             16'sh8000, 16'sh8000, 16'sh8000};
        logic signed [DMG_W-1:0] thalf[6] = '{8192, 24576, 0, 4096, -4096, 2048};
        send_node(px, tone, 1'b1);
        send_node(p0, t0, 1'b0);
        send_node(px, t0, 1'b1);
        send_node(pmax, tmax, 1'b0);
        send_node(pmin, tmin, 1'b1);
        send_node(pmin, tmax, 1'b0);
        send_node(pmax, tmin, 1'b1);
        send_node(px, thalf, 1'b0);
        send_node(px, tone, 1'b1);
        send_node(p0, tmax, 1'b0);
        send_node(pyz, thalf, 1'b0);
        send_node(p0, tone, 1'b1);
        send_node(px, tone, 1'b0);
        send_node(pyz, thalf, 1'b1);
        send_node(p0, tmax, 1'b0);
        send_node(px, t0, 1'b1);
        send_node(pyz, tmin, 1'b0);
        send_node(p0, tmax, 1'b1);
        send_node(px, thalf, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int s_pct, input int r_pct, input int pairs);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < pairs; i++) send_random_pair(i % 4);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 600;
        for (int i = 0; i < 8; i++) send_random_pair(1);
        wait_drained();
        for (int i = 0; i < 4; i++) send_random_pair(0);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        coupling_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %0d", coupling);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.cpl !== coupling || e.sat !== saturated || e.coin !== coincident)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 e.cpl, e.sat, e.coin, coupling, saturated, coincident);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        node_held = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(15, 70, 200);
        test_random(70, 15, 200);
        test_backpressure();
        test_random(0, 0, 200);
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
